@@ rtl/core/imubw_pkg.sv @@
// imubw_pkg: shared types, constants and saturation helpers for the imu biquad filter
// used by every module under rtl/core; depends on nothing else
package imubw_pkg;

  localparam int AXIS_COUNT     = 6;
  localparam int STAGE_COUNT    = 2;
  localparam int COEF_FRAC_BITS = 28;

  localparam int NUM_FIELDS   = 6;
  localparam int ACCEL_FIELDS = 3;
  localparam int NUM_REGS     = 6;
  localparam int CFG_ADDR_W   = $clog2(NUM_REGS);

  localparam int RAW_W   = 16;
  localparam int SCALE_W = 17;
  localparam int SIG_W   = 32;
  localparam int COEF_W  = 32;
  localparam int PROD_W  = COEF_W + SIG_W;
  localparam int RND_W   = PROD_W - COEF_FRAC_BITS;
  localparam int DELAY_W = 48;
  localparam int SUM_W   = DELAY_W + 3;
  localparam int OUT_W   = 16;
  localparam int DATA_W  = NUM_FIELDS * RAW_W;
  localparam int STG_W   = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

  localparam logic signed [SCALE_W-1:0] ACCEL_SCALE = 17'sd40168;
  localparam logic signed [SCALE_W-1:0] GYRO_SCALE  = 17'sd35764;

  localparam logic [CFG_ADDR_W-1:0] REG_S0_B0 = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_S0_A1 = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_S0_A2 = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_S1_B0 = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] REG_S1_A1 = CFG_ADDR_W'(4);
  localparam logic [CFG_ADDR_W-1:0] REG_S1_A2 = CFG_ADDR_W'(5);

  localparam logic signed [COEF_W-1:0] RST_S0_B0 = 32'sd16612128;
  localparam logic signed [COEF_W-1:0] RST_S0_A1 = -32'sd281480350;
  localparam logic signed [COEF_W-1:0] RST_S0_A2 = 32'sd79495281;
  localparam logic signed [COEF_W-1:0] RST_S1_B0 = 32'sd20926155;
  localparam logic signed [COEF_W-1:0] RST_S1_A1 = -32'sd354582031;
  localparam logic signed [COEF_W-1:0] RST_S1_A2 = 32'sd169851729;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_FILT,
    ST_DONE
  } st_t;

  typedef enum logic [1:0] {
    COEF_B0,
    COEF_A1,
    COEF_A2
  } coef_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_P,
    ACT_PY,
    ACT_W1,
    ACT_W2
  } act_t;

  typedef struct packed {
    logic             load;
    coef_sel_t        coef_sel;
    act_t             act;
    logic [STG_W-1:0] stage;
  } ctl_t;

  typedef logic signed [SIG_W-1:0] sig_t;

  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [SUM_W-1:0] v);
    if (v[SUM_W-1:DELAY_W-1] == '0 || v[SUM_W-1:DELAY_W-1] == '1) begin
      return v[DELAY_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DELAY_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DELAY_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [SUM_W-1:0] v);
    if (v[SUM_W-1:SIG_W-1] == '0 || v[SUM_W-1:SIG_W-1] == '1) begin
      return v[SIG_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(SIG_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SIG_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/core/imubw_ctrl.sv @@
// imubw_ctrl: sequencer that steps all lanes through priming and the biquad cascade
// depends on imubw_pkg
module imubw_ctrl
  import imubw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic primed,
  input  logic out_free,
  output logic in_ready,
  output ctl_t ctl,
  output logic prime_done,
  output logic out_load
);

  // priming schedule, one stage
  localparam logic [2:0] P_MUL_B0 = 3'd0;
  localparam logic [2:0] P_MUL_A2 = 3'd1;
  localparam logic [2:0] P_MUL_A1 = 3'd2;
  localparam logic [2:0] P_W2     = 3'd3;
  localparam logic [2:0] P_W1     = 3'd4;
  // filter schedule, one stage
  localparam logic [2:0] F_MUL_B0 = 3'd0;
  localparam logic [2:0] F_WAIT   = 3'd1;
  localparam logic [2:0] F_Y      = 3'd2;
  localparam logic [2:0] F_MUL_A1 = 3'd3;
  localparam logic [2:0] F_MUL_A2 = 3'd4;
  localparam logic [2:0] F_W1     = 3'd5;
  localparam logic [2:0] F_W2     = 3'd6;

  localparam logic [STG_W-1:0] STG_LAST = STG_W'(STAGE_COUNT - 1);

  st_t              state, state_next;
  logic [2:0]       sub;
  logic [STG_W-1:0] stg;
  logic             in_accept;

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = primed ? ST_FILT : ST_PRIME;
        end
      end
      ST_PRIME: begin
        if (sub == P_W1 && stg == STG_LAST) begin
          state_next = ST_FILT;
        end
      end
      ST_FILT: begin
        if (sub == F_W2 && stg == STG_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.load     = 1'b0;
    ctl.coef_sel = COEF_B0;
    ctl.act      = ACT_NONE;
    ctl.stage    = stg;
    prime_done   = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        ctl.load = in_accept;
      end
      ST_PRIME: begin
        case (sub)
          P_MUL_B0: ctl.coef_sel = COEF_B0;
          P_MUL_A2: ctl.coef_sel = COEF_A2;
          P_MUL_A1: begin
            ctl.coef_sel = COEF_A1;
            ctl.act      = ACT_P;
          end
          P_W2: ctl.act = ACT_W2;
          P_W1: begin
            ctl.act    = ACT_W1;
            prime_done = (stg == STG_LAST);
          end
          default: ctl.act = ACT_NONE;
        endcase
      end
      ST_FILT: begin
        case (sub)
          F_MUL_B0: ctl.coef_sel = COEF_B0;
          F_WAIT:   ctl.act = ACT_NONE;
          F_Y:      ctl.act = ACT_PY;
          F_MUL_A1: ctl.coef_sel = COEF_A1;
          F_MUL_A2: ctl.coef_sel = COEF_A2;
          F_W1:     ctl.act = ACT_W1;
          F_W2:     ctl.act = ACT_W2;
          default:  ctl.act = ACT_NONE;
        endcase
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ctl.act = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sub   <= '0;
      stg   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        sub <= '0;
        stg <= '0;
      end else if ((state == ST_PRIME && sub == P_W1) || (state == ST_FILT && sub == F_W2)) begin
        sub <= '0;
        stg <= stg + STG_W'(1);
      end else if (state == ST_PRIME || state == ST_FILT) begin
        sub <= sub + 3'd1;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_PRIME || state == ST_FILT) && sub == '0 && stg == '0)
    else $error("accepted item did not start the sequence");

  a_prime_to_filt: assert property (@(posedge clk) disable iff (rst)
    prime_done |=> state == ST_FILT && sub == '0 && stg == '0)
    else $error("priming did not hand over to filtering");

  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRIME |-> sub <= P_W1) and (state == ST_FILT |-> sub <= F_W2))
    else $error("schedule step out of range");

endmodule

@@ rtl/core/imubw_lane.sv @@
// imubw_lane: one axis: input scaling, shared multiplier and biquad delay terms
// depends on imubw_pkg; driven by imubw_ctrl through ctl_t
module imubw_lane
  import imubw_pkg::*;
(
  input  logic                      clk,
  input  ctl_t                      ctl,
  input  logic signed [COEF_W-1:0]  coef,
  input  logic signed [RAW_W-1:0]   raw,
  input  logic signed [SCALE_W-1:0] scale,
  input  logic                      enable,
  output sig_t                      result
);

  localparam int SCALED_W = RAW_W + SCALE_W;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);

  sig_t                      v;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [RND_W-1:0]   rnd;
  logic signed [RND_W-1:0]   p;
  logic signed [DELAY_W-1:0] w1 [STAGE_COUNT];
  logic signed [DELAY_W-1:0] w2 [STAGE_COUNT];
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SUM_W-1:0]   rnd_e, p_e, w1_e, w2_e;
  logic signed [SUM_W-1:0]   w1_sum, w2_sum;

  // round half up, then floor shift
  function automatic logic signed [PROD_W-1:0] prod_r_calc(input logic signed [PROD_W-1:0] x);
    return (x + ROUND_HALF) >>> COEF_FRAC_BITS;
  endfunction

  assign scaled = SCALED_W'(raw) * SCALED_W'(scale);
  assign prod   = coef * v;
  assign prod_r = prod_r_calc(prod_q);

  assign rnd_e  = SUM_W'(rnd);
  assign p_e    = SUM_W'(p);
  assign w1_e   = SUM_W'(w1[ctl.stage]);
  assign w2_e   = SUM_W'(w2[ctl.stage]);
  assign w1_sum = (p_e <<< 1) - rnd_e + w2_e;
  assign w2_sum = p_e - rnd_e;

  // product register; the rounded product is registered in the cycle after
  always_ff @(posedge clk) begin
    prod_q <= prod;
  end

  always_ff @(posedge clk) begin
    rnd <= prod_r[RND_W-1:0];
    if (ctl.load) begin
      v <= scaled[SIG_W-1:0];
    end
    if (enable) begin
      case (ctl.act)
        ACT_P:  p <= rnd;
        ACT_PY: begin
          p <= rnd;
          v <= sat_sig(SUM_W'(rnd) + w1_e);
        end
        ACT_W1: w1[ctl.stage] <= sat_delay(w1_sum);
        ACT_W2: w2[ctl.stage] <= sat_delay(w2_sum);
        default: ;
      endcase
    end
  end

  assign result = v;

endmodule

@@ rtl/core/imubw_out.sv @@
// imubw_out: merges lane results into one output item, rounds to the output unit
// and holds it in the output register; depends on imubw_pkg
module imubw_out
  import imubw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sig_t              vals [NUM_FIELDS],
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [DATA_W-1:0] m_tdata,
  output logic              free
);

  localparam int EXT_W = SIG_W + 1;
  localparam int SHR_W = EXT_W - OUT_W;
  localparam logic signed [EXT_W-1:0] HALF_LSB = EXT_W'(1) <<< (OUT_W - 1);

  function automatic logic [OUT_W-1:0] to_out(input sig_t v);
    logic signed [EXT_W-1:0] e;
    logic signed [SHR_W-1:0] s;
    e = EXT_W'(v) + HALF_LSB;
    s = e[EXT_W-1:OUT_W];
    if (s[SHR_W-1:OUT_W-1] == '0 || s[SHR_W-1:OUT_W-1] == '1) begin
      return s[OUT_W-1:0];
    end else if (s[SHR_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int a = 0; a < NUM_FIELDS; a++) begin
        m_tdata[a*OUT_W +: OUT_W] <= to_out(vals[a]);
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while an item waits");

endmodule

@@ rtl/core/imu_six_axis_butterworth_filter.sv @@
// imu_six_axis_butterworth_filter: top level, coefficient registers and lane array
// depends on imubw_pkg, imubw_ctrl, imubw_lane, imubw_out
//
// Usage:
//  s_tdata carries one six-axis raw sample; m_tdata returns the filtered sample,
//  accel in m/s^2 Q10 and gyro in rad/s Q12, each saturated to 16 bits.
//  Coefficients are written through cfg_we/cfg_addr/cfg_data; the user must do so
//  only while the block is idle, which the block itself does not enforce; writes to
//  an index past the last register are dropped. Six lanes run side by side, one per
//  axis; each owns one 32x32 multiplier that is shared over the biquad steps, and
//  the output stage merges the lane results into the output register.
//  The first item after reset or after a coefficient write primes the delay terms
//  before it is filtered. A new item is accepted only once the previous result has
//  moved to the output register; s_tready is high only between items, and an item
//  may be accepted while the previous result waits.
//  If m_tready stays low, the finished result waits in the output register and
//  the next result holds in its lanes until the register frees.
//  Reset restores the default coefficients and forces priming on the next item.
module imu_six_axis_butterworth_filter
  import imubw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  logic [DATA_W-1:0]     s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // accel_x_filtered, accel_y_filtered, accel_z_filtered,
  // gyro_x_filtered, gyro_y_filtered, gyro_z_filtered
  output logic [DATA_W-1:0]     m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COEF_W-1:0]     cfg_data
);

  logic signed [COEF_W-1:0] s0_b0, s0_a1, s0_a2, s1_b0, s1_a1, s1_a2;
  logic signed [COEF_W-1:0] coef;
  logic                     primed;
  logic                     prime_done;
  logic                     out_load;
  logic                     out_free;
  logic                     cfg_hit;
  ctl_t                     ctl;
  sig_t                     lane_vals [NUM_FIELDS];

  assign cfg_hit = cfg_we && (cfg_addr < CFG_ADDR_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_b0  <= RST_S0_B0;
      s0_a1  <= RST_S0_A1;
      s0_a2  <= RST_S0_A2;
      s1_b0  <= RST_S1_B0;
      s1_a1  <= RST_S1_A1;
      s1_a2  <= RST_S1_A2;
      primed <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_S0_B0: s0_b0 <= cfg_data;
          REG_S0_A1: s0_a1 <= cfg_data;
          REG_S0_A2: s0_a2 <= cfg_data;
          REG_S1_B0: s1_b0 <= cfg_data;
          REG_S1_A1: s1_a1 <= cfg_data;
          REG_S1_A2: s1_a2 <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        primed <= 1'b0;
      end else if (prime_done) begin
        primed <= 1'b1;
      end
    end
  end

  // stages past the first all share the second coefficient set
  always_comb begin
    case (ctl.coef_sel)
      COEF_B0: coef = (ctl.stage == '0) ? s0_b0 : s1_b0;
      COEF_A1: coef = (ctl.stage == '0) ? s0_a1 : s1_a1;
      COEF_A2: coef = (ctl.stage == '0) ? s0_a2 : s1_a2;
      default: coef = s0_b0;
    endcase
  end

  imubw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .primed     (primed),
    .out_free   (out_free),
    .in_ready   (s_tready),
    .ctl        (ctl),
    .prime_done (prime_done),
    .out_load   (out_load)
  );

  for (genvar a = 0; a < NUM_FIELDS; a++) begin : g_lane
    imubw_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .coef   (coef),
      .raw    ($signed(s_tdata[a*RAW_W +: RAW_W])),
      .scale  ((a < ACCEL_FIELDS) ? ACCEL_SCALE : GYRO_SCALE),
      .enable ((a < AXIS_COUNT) ? 1'b1 : 1'b0),
      .result (lane_vals[a])
    );
  end

  imubw_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .vals     (lane_vals),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .free     (out_free)
  );

  a_cfg_unprimes: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> !primed)
    else $error("coefficient write did not force priming");

  a_prime_only_unprimed: assert property (@(posedge clk) disable iff (rst)
    prime_done |-> !primed)
    else $error("priming ran while already primed");

endmodule
